/* rtl/lbfm_pkg.sv */
// Shared types and constants for the LRU buffer frame manager.
// Request codes, field widths and the controller/datapath command and status groups.
`timescale 1ns / 1ps

package lbfm_pkg;

   localparam int REQ_KIND_W  = 3;
   localparam int PAGE_W      = 16;
   localparam int FRAME_W     = 4;
   localparam int TOTAL_W     = 32;
   localparam int FIX_W       = 8;
   localparam int MAX_RESULTS = 16;
   localparam int LIST_CNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int REQ_DATA_W  = 24;

   localparam logic [REQ_KIND_W-1:0] REQ_FIX       = 3'd0;
   localparam logic [REQ_KIND_W-1:0] REQ_UNFIX     = 3'd1;
   localparam logic [REQ_KIND_W-1:0] REQ_SET_DIRTY = 3'd2;
   localparam logic [REQ_KIND_W-1:0] REQ_CLR_DIRTY = 3'd3;
   localparam logic [REQ_KIND_W-1:0] REQ_FLUSH     = 3'd4;

   // Result beat payload, first member in the highest bits.
   typedef struct packed {
      logic [TOTAL_W-1:0] writeback_total;
      logic [TOTAL_W-1:0] miss_total;
      logic [TOTAL_W-1:0] hit_total;
      logic               error;
      logic               needs_writeback;
      logic [PAGE_W-1:0]  victim_page;
      logic               evicted;
      logic               was_hit;
      logic [FRAME_W-1:0] frame_index;
   } rsp_type;

   localparam int RSP_DATA_W = $bits(rsp_type);

   typedef struct packed {
      logic load;        // capture the accepted request, clear scan results
      logic scan;        // the read issued this cycle belongs to a lookup scan
      logic exec;        // finish a single-result request and emit its beat
      logic list_emit;   // emit the dirty frame under the read pointer
      logic empty_emit;  // emit the lone beat of a flush with nothing dirty
   } cmd_type;

   typedef struct packed {
      logic out_free;    // output register can take a beat this cycle
      logic dirty_here;  // frame under the read pointer is valid and dirty
      logic list_last;   // that frame is the final one to be listed
   } status_type;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      sat_inc = (v == '1) ? v : v + TOTAL_W'(1);
   endfunction

endpackage

/* rtl/lbfm_datapath.sv */
// Datapath of the LRU buffer frame manager: frame memories, valid/dirty bits,
// scan trackers, totals and the result output register. Uses lbfm_pkg.
`timescale 1ns / 1ps

module lbfm_datapath import lbfm_pkg::*; #(
   parameter int FRAMES     = 16,
   parameter int PAGE_BITS  = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [REQ_KIND_W-1:0]           req_kind,
   input  logic [PAGE_W-1:0]               req_page,
   input  logic [FRAME_W-1:0]              req_frame,
   input  cmd_type                         cmd,
   input  logic [$clog2(FRAMES)-1:0]       scan_addr,
   output status_type                      status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output rsp_type                         rsp_data,
   output logic                            rsp_last
);

   localparam int FIDX  = $clog2(FRAMES);
   localparam int TAG_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
   // one bit above both the frame field and the index so FRAMES itself fits
   localparam int FN_W  = ((FIDX > FRAME_W) ? FIDX : FRAME_W) + 1;

   // frame memories, written only when a frame is filled or touched
   logic [TAG_W-1:0]      tag_mem   [FRAMES];
   logic [FIX_W-1:0]      fix_mem   [FRAMES];
   logic [STAMP_BITS-1:0] stamp_mem [FRAMES];

   logic [TAG_W-1:0]      tag_rd_ff;
   logic [FIX_W-1:0]      fix_rd_ff;
   logic [STAMP_BITS-1:0] stamp_rd_ff;
   logic [FIDX-1:0]       rd_idx_ff;
   logic                  live_ff, live_in;

   logic [REQ_KIND_W-1:0] kind_ff, kind_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic [FRAME_W-1:0]    fn_ff, fn_in;

   logic                  match_found_ff, match_found_in;
   logic [FIDX-1:0]       match_idx_ff, match_idx_in;
   logic [FIX_W-1:0]      match_fix_ff, match_fix_in;
   logic                  free_found_ff, free_found_in;
   logic [FIDX-1:0]       free_idx_ff, free_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [FIDX-1:0]       best_idx_ff, best_idx_in;
   logic [STAMP_BITS-1:0] best_age_ff, best_age_in;
   logic [TAG_W-1:0]      best_tag_ff, best_tag_in;

   logic [FRAMES-1:0]     valid_ff, valid_in;
   logic [FRAMES-1:0]     dirty_ff, dirty_in;
   logic [STAMP_BITS-1:0] stamp_cnt_ff, stamp_cnt_in;
   logic [TOTAL_W-1:0]    hit_ff, hit_in;
   logic [TOTAL_W-1:0]    miss_ff, miss_in;
   logic [TOTAL_W-1:0]    wb_ff, wb_in;
   logic [LIST_CNT_W-1:0] list_cnt_ff, list_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  last_ff, last_in;

   logic                  wr_fs, wr_tag;
   logic [FIDX-1:0]       wr_idx;
   logic [FIX_W-1:0]      wr_fix;
   logic [STAMP_BITS-1:0] age;
   logic [FIDX-1:0]       miss_idx;
   logic [FN_W-1:0]       fn_wide;
   logic [FIDX-1:0]       fn_idx;
   logic                  fn_ok;
   logic [FRAMES-1:0]     above;
   logic                  more_dirty;
   logic                  emit;

   assign age      = stamp_cnt_ff - stamp_rd_ff;
   assign miss_idx = free_found_ff ? free_idx_ff : best_idx_ff;
   assign fn_wide  = FN_W'(fn_ff);
   assign fn_idx   = FIDX'(fn_wide);
   assign fn_ok    = (fn_wide < FN_W'(FRAMES)) && valid_ff[fn_idx];

   always_comb begin
      for (int j = 0; j < FRAMES; j++) begin
         above[j] = (FIDX'(j) > rd_idx_ff);
      end
   end

   assign more_dirty        = |(valid_ff & dirty_ff & above);
   assign status.dirty_here = valid_ff[rd_idx_ff] & dirty_ff[rd_idx_ff];
   assign status.list_last  = (list_cnt_ff == LIST_CNT_W'(MAX_RESULTS - 1)) || !more_dirty;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign emit              = cmd.exec | cmd.list_emit | cmd.empty_emit;

   always_comb begin
      live_in        = cmd.scan;
      kind_in        = kind_ff;
      tag_in         = tag_ff;
      fn_in          = fn_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_fix_in   = match_fix_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_age_in    = best_age_ff;
      best_tag_in    = best_tag_ff;
      valid_in       = valid_ff;
      dirty_in       = dirty_ff;
      stamp_cnt_in   = stamp_cnt_ff;
      hit_in         = hit_ff;
      miss_in        = miss_ff;
      wb_in          = wb_ff;
      list_cnt_in    = list_cnt_ff;
      wr_fs          = 1'b0;
      wr_tag         = 1'b0;
      wr_idx         = match_idx_ff;
      wr_fix         = match_fix_ff;
      rsp_in         = '0;
      last_in        = 1'b1;

      if (cmd.load) begin
         kind_in        = req_kind;
         tag_in         = req_page[TAG_W-1:0];
         fn_in          = req_frame;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         best_found_in  = 1'b0;
         list_cnt_in    = '0;
      end

      // evaluate the frame read in the previous cycle
      if (live_ff) begin
         if (valid_ff[rd_idx_ff]) begin
            if (!match_found_ff && tag_rd_ff == tag_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = rd_idx_ff;
               match_fix_in   = fix_rd_ff;
            end
            if (!best_found_ff || age > best_age_ff) begin
               best_found_in = 1'b1;
               best_idx_in   = rd_idx_ff;
               best_age_in   = age;
               best_tag_in   = tag_rd_ff;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      if (cmd.exec) begin
         unique case (kind_ff)
            REQ_FIX: begin
               wr_fs        = 1'b1;
               stamp_cnt_in = stamp_cnt_ff + STAMP_BITS'(1);
               if (match_found_ff) begin
                  wr_fix             = (match_fix_ff == '1) ? match_fix_ff
                                                           : match_fix_ff + FIX_W'(1);
                  hit_in             = sat_inc(hit_ff);
                  rsp_in.frame_index = FRAME_W'(match_idx_ff);
                  rsp_in.was_hit     = 1'b1;
               end else begin
                  wr_tag             = 1'b1;
                  wr_idx             = miss_idx;
                  wr_fix             = FIX_W'(1);
                  miss_in            = sat_inc(miss_ff);
                  valid_in[miss_idx] = 1'b1;
                  dirty_in[miss_idx] = 1'b0;
                  rsp_in.frame_index = FRAME_W'(miss_idx);
                  if (!free_found_ff) begin
                     rsp_in.evicted     = 1'b1;
                     rsp_in.victim_page = PAGE_W'(best_tag_ff);
                     if (dirty_ff[best_idx_ff]) begin
                        rsp_in.needs_writeback = 1'b1;
                        wb_in                  = sat_inc(wb_ff);
                     end
                  end
               end
            end
            REQ_UNFIX: begin
               if (match_found_ff) begin
                  wr_fs              = 1'b1;
                  wr_fix             = (match_fix_ff == '0) ? match_fix_ff
                                                           : match_fix_ff - FIX_W'(1);
                  stamp_cnt_in       = stamp_cnt_ff + STAMP_BITS'(1);
                  rsp_in.frame_index = FRAME_W'(match_idx_ff);
               end else begin
                  rsp_in.error = 1'b1;
               end
            end
            REQ_SET_DIRTY, REQ_CLR_DIRTY: begin
               rsp_in.frame_index = fn_ff;
               if (fn_ok) begin
                  dirty_in[fn_idx] = (kind_ff == REQ_SET_DIRTY);
               end else begin
                  rsp_in.error = 1'b1;
               end
            end
            default: begin
               rsp_in.error = 1'b1;
            end
         endcase
      end

      if (cmd.list_emit) begin
         wb_in                  = sat_inc(wb_ff);
         list_cnt_in            = list_cnt_ff + LIST_CNT_W'(1);
         rsp_in.frame_index     = FRAME_W'(rd_idx_ff);
         rsp_in.victim_page     = PAGE_W'(tag_rd_ff);
         rsp_in.needs_writeback = 1'b1;
         last_in                = status.list_last;
      end

      rsp_in.hit_total       = hit_in;
      rsp_in.miss_total      = miss_in;
      rsp_in.writeback_total = wb_in;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff        <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         best_found_ff  <= 1'b0;
         valid_ff       <= '0;
         dirty_ff       <= '0;
         stamp_cnt_ff   <= '0;
         hit_ff         <= '0;
         miss_ff        <= '0;
         wb_ff          <= '0;
         list_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         live_ff        <= live_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         best_found_ff  <= best_found_in;
         valid_ff       <= valid_in;
         dirty_ff       <= dirty_in;
         stamp_cnt_ff   <= stamp_cnt_in;
         hit_ff         <= hit_in;
         miss_ff        <= miss_in;
         wb_ff          <= wb_in;
         list_cnt_ff    <= list_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      tag_ff       <= tag_in;
      fn_ff        <= fn_in;
      match_idx_ff <= match_idx_in;
      match_fix_ff <= match_fix_in;
      free_idx_ff  <= free_idx_in;
      best_idx_ff  <= best_idx_in;
      best_age_ff  <= best_age_in;
      best_tag_ff  <= best_tag_in;
      rd_idx_ff    <= scan_addr;
      if (emit) begin
         rsp_ff  <= rsp_in;
         last_ff <= last_in;
      end
   end

   // frame memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_fs) begin
         fix_mem[wr_idx]   <= wr_fix;
         stamp_mem[wr_idx] <= stamp_cnt_ff;
      end
      if (wr_tag) begin
         tag_mem[wr_idx] <= tag_ff;
      end
      tag_rd_ff   <= tag_mem[scan_addr];
      fix_rd_ff   <= fix_mem[scan_addr];
      stamp_rd_ff <= stamp_mem[scan_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign rsp_last   = last_ff;

endmodule

/* rtl/lbfm_control.sv */
// Controller of the LRU buffer frame manager: request sequencing and frame pointer.
// Drives lbfm_datapath through cmd_type and reads status_type from lbfm_pkg.
`timescale 1ns / 1ps

module lbfm_control import lbfm_pkg::*; #(
   parameter int FRAMES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_KIND_W-1:0]     req_kind,
   input  status_type                status,
   output cmd_type                   cmd,
   output logic [$clog2(FRAMES)-1:0] scan_addr
);

   localparam int FIDX = $clog2(FRAMES);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_DRAIN   = 3'd2;
   localparam logic [2:0] ST_EXEC    = 3'd3;
   localparam logic [2:0] ST_LIST_RD = 3'd4;
   localparam logic [2:0] ST_LIST_CK = 3'd5;
   localparam logic [2:0] ST_EMPTY   = 3'd6;

   logic [2:0]      state_ff, state_in;
   logic [FIDX-1:0] ptr_ff, ptr_in;
   logic            at_end;

   assign at_end     = (ptr_ff == FIDX'(FRAMES - 1));
   assign req_tready = (state_ff == ST_IDLE);
   assign scan_addr  = ptr_ff;

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               ptr_in   = '0;
               priority if (req_kind == REQ_FIX || req_kind == REQ_UNFIX) begin
                  state_in = ST_SCAN;
               end else if (req_kind == REQ_FLUSH) begin
                  state_in = ST_LIST_RD;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (at_end) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + FIDX'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LIST_RD: begin
            state_in = ST_LIST_CK;
         end
         ST_LIST_CK: begin
            if (status.dirty_here) begin
               if (status.out_free) begin
                  cmd.list_emit = 1'b1;
                  if (status.list_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     ptr_in   = ptr_ff + FIDX'(1);
                     state_in = ST_LIST_RD;
                  end
               end
            end else if (at_end) begin
               state_in = ST_EMPTY;
            end else begin
               ptr_in   = ptr_ff + FIDX'(1);
               state_in = ST_LIST_RD;
            end
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd.empty_emit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

endmodule

/* rtl/lru_buffer_frame_manager.sv */
// Top level of the LRU buffer frame manager: stream ports, controller and datapath.
// Depends on lbfm_pkg, lbfm_control and lbfm_datapath.
//
//   channel | dir | tvalid/tready          | payload
//   --------+-----+------------------------+--------------------------------------
//   req     | in  | req_tvalid/req_tready  | req_tuser kind, req_tdata page+frame
//   rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata result+totals, rsp_tlast
//
// One request is worked at a time. Fix and unfix walk every frame through the
// single read port of the frame memories, one frame a cycle, then execute once
// the output register is free. Set and clear dirty go from accept straight to
// execute. A flush visits frames in turn, a read state then a check state for
// each, gives one empty beat if nothing is dirty and waits on a stalled rsp side.
// Reset is synchronous and clears all frames to empty; no clearing pass runs.
// A finished beat sits in the output register; the next request is accepted
// while it waits, and a stalled rsp side holds the controller before its emit.
`timescale 1ns / 1ps

module lru_buffer_frame_manager import lbfm_pkg::*; #(
   parameter int FRAMES     = 16,
   parameter int PAGE_BITS  = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // page_number [15:0], frame_number [19:16], zero [23:20]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type [2:0]
   input  logic [REQ_KIND_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // frame_index [3:0], was_hit [4], evicted [5], victim_page [21:6],
   // needs_writeback [22], error [23], hit_total [55:24], miss_total [87:56],
   // writeback_total [119:88]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int FIDX = $clog2(FRAMES);

   cmd_type         cmd;
   status_type      status;
   logic [FIDX-1:0] scan_addr;
   rsp_type         rsp_data;
   logic            rsp_last;

   lbfm_control #(
      .FRAMES (FRAMES)
   ) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd),
      .scan_addr  (scan_addr)
   );

   // hold the frame state, walk the memories and build each result beat
   lbfm_datapath #(
      .FRAMES     (FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_tuser),
      .req_page   (req_tdata[PAGE_W-1:0]),
      .req_frame  (req_tdata[PAGE_W+FRAME_W-1:PAGE_W]),
      .cmd        (cmd),
      .scan_addr  (scan_addr),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

   assign rsp_tdata = rsp_data;
   assign rsp_tlast = rsp_last;

   // an accepted beat always leaves the controller out of idle in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted twice in a row");

   // a beat is only emitted into a free output register
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec || cmd.list_emit || cmd.empty_emit) |-> (!rsp_tvalid || rsp_tready))
      else $error("result emitted over a waiting beat");

   // capture and emit never coincide, and at most one emit kind fires
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.exec, cmd.list_emit, cmd.empty_emit}))
      else $error("conflicting controller commands");

   // an exec or empty-flush emit returns the controller to idle
   a_emit_then_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec || cmd.empty_emit) |=> req_tready)
      else $error("controller did not return to idle after final beat");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for lru_buffer_frame_manager: directed and random requests,
// checked beat by beat against an LRU frame pool predictor. Depends on lbfm_pkg.
`timescale 1ns / 1ps

module tb_top;
   import lbfm_pkg::*;

   localparam int POOL_FRAMES = 16;
   localparam int PAGE_POOL   = 24;
   localparam int MAX_IDLE    = 13;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 3 * POOL_FRAMES + 16;

   // request kinds with no meaning to the block
   localparam logic [REQ_KIND_W-1:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [REQ_KIND_W-1:0] REQ_UNUSED_LAST  = 3'd7;

   typedef struct {
      rsp_type beat;
      logic    last;
   } rsp_expect_type;

   // Predicts the result beats of each accepted request and checks what comes out.
   class frame_pool_scoreboard;
      bit                 frame_used  [POOL_FRAMES];
      logic [PAGE_W-1:0]  frame_tag   [POOL_FRAMES];
      bit                 frame_dirty [POOL_FRAMES];
      logic [FIX_W-1:0]   frame_fixes [POOL_FRAMES];
      logic [31:0]        frame_stamp [POOL_FRAMES];
      logic [31:0]        stamp_ctr;
      logic [TOTAL_W-1:0] hits, misses, writebacks;
      rsp_expect_type     pending_beats[$];
      int                 failures, requests, beats, evictions, listed;
      int                 kind_seen [8];

      function new();
         foreach (frame_used[i]) begin
            frame_used[i]  = 1'b0;
            frame_dirty[i] = 1'b0;
            frame_fixes[i] = '0;
         end
         stamp_ctr  = '0;
         hits       = '0;
         misses     = '0;
         writebacks = '0;
      endfunction

      function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      function logic [31:0] take_stamp();
         take_stamp = stamp_ctr;
         stamp_ctr  = stamp_ctr + 1'b1;
      endfunction

      function int lookup(logic [PAGE_W-1:0] page);
         for (int i = 0; i < POOL_FRAMES; i++)
            if (frame_used[i] && frame_tag[i] == page) return i;
         return -1;
      endfunction

      // stamp the totals as they stand after this beat's update
      function void queue_beat(rsp_type r, logic last);
         rsp_expect_type e;
         r.hit_total       = hits;
         r.miss_total      = misses;
         r.writeback_total = writebacks;
         e.beat = r;
         e.last = last;
         pending_beats.insert(pending_beats.size(), e);
      endfunction

      function void note_request(logic [REQ_KIND_W-1:0] kind, logic [PAGE_W-1:0] page,
                                 logic [FRAME_W-1:0] frame);
         rsp_type     r;
         int          slot;
         int          n;
         logic [31:0] age, oldest;
         r = '0;
         requests++;
         kind_seen[kind]++;
         case (kind)
            REQ_FIX: begin
               slot = lookup(page);
               if (slot >= 0) begin
                  if (frame_fixes[slot] != '1) frame_fixes[slot]++;
                  frame_stamp[slot] = take_stamp();
                  hits = bump(hits);
                  r.frame_index = slot[FRAME_W-1:0];
                  r.was_hit = 1'b1;
               end else begin
                  for (int i = POOL_FRAMES - 1; i >= 0; i--)
                     if (!frame_used[i]) slot = i;
                  if (slot < 0) begin
                     // pool full: evict the oldest stamp, lowest index on ties
                     slot = 0;
                     oldest = '0;
                     for (int i = 0; i < POOL_FRAMES; i++) begin
                        age = stamp_ctr - frame_stamp[i];
                        if (i == 0 || age > oldest) begin
                           oldest = age;
                           slot = i;
                        end
                     end
                     r.evicted = 1'b1;
                     r.victim_page = frame_tag[slot];
                     r.needs_writeback = frame_dirty[slot];
                     if (frame_dirty[slot]) writebacks = bump(writebacks);
                     evictions++;
                  end
                  misses = bump(misses);
                  frame_used[slot]  = 1'b1;
                  frame_tag[slot]   = page;
                  frame_dirty[slot] = 1'b0;
                  frame_fixes[slot] = FIX_W'(1);
                  frame_stamp[slot] = take_stamp();
                  r.frame_index = slot[FRAME_W-1:0];
               end
               queue_beat(r, 1'b1);
            end
            REQ_UNFIX: begin
               slot = lookup(page);
               if (slot < 0) begin
                  r.error = 1'b1;
               end else begin
                  if (frame_fixes[slot] != 0) frame_fixes[slot]--;
                  frame_stamp[slot] = take_stamp();
                  r.frame_index = slot[FRAME_W-1:0];
               end
               queue_beat(r, 1'b1);
            end
            REQ_SET_DIRTY, REQ_CLR_DIRTY: begin
               r.frame_index = frame;
               if (!frame_used[frame]) r.error = 1'b1;
               else frame_dirty[frame] = (kind == REQ_SET_DIRTY);
               queue_beat(r, 1'b1);
            end
            REQ_FLUSH: begin
               n = 0;
               for (int i = 0; i < POOL_FRAMES && n < MAX_RESULTS; i++) begin
                  if (frame_used[i] && frame_dirty[i]) begin
                     writebacks = bump(writebacks);
                     r = '0;
                     r.frame_index = i[FRAME_W-1:0];
                     r.victim_page = frame_tag[i];
                     r.needs_writeback = 1'b1;
                     queue_beat(r, 1'b0);
                     n++;
                  end
               end
               listed += n;
               if (n == 0) queue_beat('0, 1'b1);
               else pending_beats[pending_beats.size() - 1].last = 1'b1;
            end
            default: begin
               r.error = 1'b1;
               queue_beat(r, 1'b1);
            end
         endcase
      endfunction

      task report(string msg);
         failures++;
         if (failures <= 40) $display("[%0t] error: %s", $time, msg);
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("beat %0d %s: got 0x%0h, want 0x%0h", beats, name, got, want));
      endtask

      task check_beat(logic [RSP_DATA_W-1:0] data, logic last);
         rsp_type        got;
         rsp_expect_type want;
         got = data;
         beats++;
         if (pending_beats.size() == 0) begin
            report($sformatf("beat %0d arrived with nothing outstanding", beats));
            return;
         end
         want = pending_beats.pop_front();
         check_field("frame_index",     got.frame_index,     want.beat.frame_index);
         check_field("was_hit",         got.was_hit,         want.beat.was_hit);
         check_field("evicted",         got.evicted,         want.beat.evicted);
         check_field("victim_page",     got.victim_page,     want.beat.victim_page);
         check_field("needs_writeback", got.needs_writeback, want.beat.needs_writeback);
         check_field("error",           got.error,           want.beat.error);
         check_field("last",            last,                want.last);
         check_field("hit_total",       got.hit_total,       want.beat.hit_total);
         check_field("miss_total",      got.miss_total,      want.beat.miss_total);
         check_field("writeback_total", got.writeback_total, want.beat.writeback_total);
      endtask

      function int outstanding();
         return pending_beats.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // page_number [15:0], frame_number [19:16]
   logic [REQ_KIND_W-1:0] req_tuser  = '0;  // req_type [2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // rsp_type, frame_index in the lowest bits
   logic                  rsp_tlast;

   bit                    no_idle  = 1'b0;  // both sides run back to back while set
   bit                    hold_rsp = 1'b0;  // receiver holds off while set
   logic [PAGE_W-1:0]     page_pool [PAGE_POOL];

   frame_pool_scoreboard  sb = new();

   lru_buffer_frame_manager #(
      .FRAMES     (POOL_FRAMES),
      .PAGE_BITS  (PAGE_W),
      .STAMP_BITS (32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sample both channels at the edge; retire beats before noting a new request,
   // since a request accepted now cannot own a beat leaving at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[PAGE_W-1:0],
                            req_tdata[PAGE_W +: FRAME_W]);
      end
   end

   // Offer one request beat after a random gap and return at the edge that takes it.
   task automatic send_req(input logic [REQ_KIND_W-1:0] kind, input logic [PAGE_W-1:0] page,
                           input logic [FRAME_W-1:0] frame);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - PAGE_W - FRAME_W){1'b0}}, frame, page};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every expected beat is back.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic reroll_pages();
      foreach (page_pool[i]) page_pool[i] = PAGE_W'($urandom_range(0, 65535));
   endtask

   function automatic logic [PAGE_W-1:0] pick_page();
      // mostly pool pages so hits, evictions and unfixes land; now and then a stray
      if ($urandom_range(0, 9) == 0) return PAGE_W'($urandom_range(0, 65535));
      return page_pool[$urandom_range(0, PAGE_POOL - 1)];
   endfunction

   task automatic run_random(input int count);
      int                    roll;
      logic [REQ_KIND_W-1:0] kind;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45)      kind = REQ_FIX;
         else if (roll < 65) kind = REQ_UNFIX;
         else if (roll < 78) kind = REQ_SET_DIRTY;
         else if (roll < 86) kind = REQ_CLR_DIRTY;
         else if (roll < 93) kind = REQ_FLUSH;
         else kind = REQ_KIND_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
         send_req(kind, pick_page(), FRAME_W'($urandom_range(0, POOL_FRAMES - 1)));
      end
   endtask

   // Send set dirty to every frame, then flush: the longest result run the block can give when all frames are in use.
   task automatic dirty_all_and_flush();
      for (int f = 0; f < POOL_FRAMES; f++)
         send_req(REQ_SET_DIRTY, pick_page(), FRAME_W'(f));
      send_req(REQ_FLUSH, pick_page(), FRAME_W'($urandom_range(0, POOL_FRAMES - 1)));
   endtask

   // Receiver: random stall per beat, forced low while hold_rsp is set.
   initial begin : drain_rsp
      int wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (wait_cycles > 0 || hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Long receiver hold-off partway in; the sender keeps offering so the block backs up.
   initial begin : rsp_backpressure
      while (sb.requests < 60) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      reroll_pages();

      // directed: fill, hit, unfix down through zero, dirty ops on live and empty
      // frames, flush with and without dirty frames, unused request kinds
      send_req(REQ_FIX,       16'h0000, 4'h0);
      send_req(REQ_FIX,       16'hFFFF, 4'hF);
      send_req(REQ_FIX,       16'hFFFF, 4'h0);
      send_req(REQ_UNFIX,     16'h1234, 4'h5);
      send_req(REQ_UNFIX,     16'hFFFF, 4'h0);
      send_req(REQ_UNFIX,     16'hFFFF, 4'h0);
      send_req(REQ_UNFIX,     16'hFFFF, 4'h0);
      send_req(REQ_SET_DIRTY, 16'h0000, 4'h1);
      send_req(REQ_SET_DIRTY, 16'hFFFF, 4'hF);
      send_req(REQ_CLR_DIRTY, 16'h5A5A, 4'hE);
      send_req(REQ_FLUSH,     16'h0000, 4'h0);
      send_req(REQ_CLR_DIRTY, 16'h0000, 4'h1);
      send_req(REQ_FLUSH,     16'hFFFF, 4'hF);
      send_req(REQ_UNUSED_FIRST,        16'hA5A5, 4'hA);
      send_req(REQ_UNUSED_FIRST + 3'd1, 16'h5A5A, 4'h5);
      send_req(REQ_UNUSED_LAST,         16'hFFFF, 4'hF);
      send_req(REQ_SET_DIRTY, 16'h0000, 4'h0);
      send_req(REQ_FIX,       16'h8001, 4'h0);
      send_req(REQ_FLUSH,     16'h0000, 4'h0);

      run_random(150);
      pause_until_drained();
      reroll_pages();
      dirty_all_and_flush();

      no_idle = 1'b1;
      run_random(60);
      no_idle = 1'b0;

      reroll_pages();
      run_random(150);
      dirty_all_and_flush();

      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (SETTLE) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.report($sformatf("%0d beats never arrived", sb.outstanding()));

      $display("covered %0d requests (fix %0d, unfix %0d, dirty %0d, flush %0d, unused %0d)",
               sb.requests, sb.kind_seen[REQ_FIX], sb.kind_seen[REQ_UNFIX],
               sb.kind_seen[REQ_SET_DIRTY] + sb.kind_seen[REQ_CLR_DIRTY],
               sb.kind_seen[REQ_FLUSH],
               sb.requests - sb.kind_seen[REQ_FIX] - sb.kind_seen[REQ_UNFIX]
               - sb.kind_seen[REQ_SET_DIRTY] - sb.kind_seen[REQ_CLR_DIRTY]
               - sb.kind_seen[REQ_FLUSH]);
      $display("checked %0d result beats: %0d evictions, %0d dirty frames listed by flush",
               sb.beats, sb.evictions, sb.listed);
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
